/* hdl/marc_pkg.sv */
// marc_pkg: shared types and codes of the mesh address resolution cache
// holds request, token, result and configuration structs; no dependencies
package marc_pkg;

    // widest index a token can carry (table holds at most 64 entries)
    localparam int SEL_W       = 6;
    localparam int MAX_RESULTS = 8;
    localparam int NRES_W      = 4;

    // opcodes
    localparam logic [1:0] OP_RESOLVE  = 2'd0;
    localparam logic [1:0] OP_RESPONSE = 2'd1;
    localparam logic [1:0] OP_UNREACH  = 2'd2;
    localparam logic [1:0] OP_TICK     = 2'd3;

    // entry states
    localparam logic [1:0] ST_INVALID = 2'd0;
    localparam logic [1:0] ST_QUERY   = 2'd1;
    localparam logic [1:0] ST_CACHED  = 2'd2;

    // result status codes
    localparam logic [1:0] STS_RESOLVED = 2'd0;
    localparam logic [1:0] STS_PENDING  = 2'd1;
    localparam logic [1:0] STS_DROPPED  = 2'd2;
    localparam logic [1:0] STS_NO_ROOM  = 2'd3;

    // result kinds
    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_NOTIFY = 1'b1;

    // register indexes
    localparam logic [1:0] REG_QTO     = 2'd0;
    localparam logic [1:0] REG_HOLD    = 2'd1;
    localparam logic [1:0] REG_INV_SID = 2'd2;
    localparam logic [1:0] REG_INV_NET = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        kind;
        logic [15:0] tsid;
        logic [15:0] tnet;
        logic [63:0] tuid;
        logic        apres;
        logic [15:0] asid;
        logic [15:0] anet;
    } t_item;

    typedef struct packed {
        logic              valid;
        logic              pass2;
        logic              done;
        logic              sel_set;
        logic [SEL_W-1:0]  sel;
        logic [NRES_W-1:0] nres;
        t_item             item;
    } t_token;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic        send;
        logic [2:0]  idx;
        logic [15:0] sid;
        logic [15:0] net;
        logic [63:0] uid;
        logic [15:0] asid;
        logic [15:0] anet;
    } t_result;

    typedef struct packed {
        logic [7:0]  qto;
        logic [7:0]  hold;
        logic [15:0] inv_sid;
        logic [15:0] inv_net;
    } t_cfg;

endpackage

/* hdl/marc_cell.sv */
// marc_cell: one table entry of the resolution cache and one token stage
// depends on marc_pkg; the token moves to the next cell every unstalled cycle
module marc_cell
    import marc_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_stall,
    input  t_cfg    i_cfg,
    input  t_token  i_tok,
    output t_token  o_tok,
    output logic    o_res_valid,
    output t_result o_res
);

    logic [1:0]  r_state, n_state;
    logic [63:0] r_uid, n_uid;
    logic [15:0] r_sid, n_sid;
    logic [15:0] r_net, n_net;
    logic [15:0] r_asid, n_asid;
    logic [15:0] r_anet, n_anet;
    logic [7:0]  r_tmo, n_tmo;
    logic [7:0]  r_hold, n_hold;
    t_token      r_tok, n_tok;

    logic id_hit;
    logic uid_hit;
    logic is_me;

    assign id_hit  = (r_sid == i_tok.item.tsid) && (r_net == i_tok.item.tnet);
    assign uid_hit = (r_uid == i_tok.item.tuid);
    assign is_me   = (i_tok.sel == SEL_W'(IDX));

    // evaluate the token against this entry
    always_comb begin
        n_state     = r_state;
        n_uid       = r_uid;
        n_sid       = r_sid;
        n_net       = r_net;
        n_asid      = r_asid;
        n_anet      = r_anet;
        n_tmo       = r_tmo;
        n_hold      = r_hold;
        n_tok       = i_tok;
        o_res_valid = 1'b0;
        o_res.kind   = KIND_ANSWER;
        o_res.status = STS_RESOLVED;
        o_res.send   = 1'b0;
        if (i_tok.valid) begin
            unique case (i_tok.item.opcode)
                OP_RESOLVE: begin
                    if (!i_tok.pass2) begin
                        // first pass: find first hit, else first free entry
                        if (!i_tok.done) begin
                            if (r_state != ST_INVALID) begin
                                if (i_tok.item.kind ? uid_hit : id_hit) begin
                                    n_tok.done    = 1'b1;
                                    n_tok.sel     = SEL_W'(IDX);
                                    n_tok.sel_set = 1'b1;
                                end
                            end else if (!i_tok.sel_set) begin
                                n_tok.sel     = SEL_W'(IDX);
                                n_tok.sel_set = 1'b1;
                            end
                        end
                    end else if (is_me) begin
                        // second pass: act on the selected entry
                        o_res_valid = 1'b1;
                        if (r_state == ST_INVALID) begin
                            n_uid   = i_tok.item.tuid;
                            n_sid   = i_tok.item.tsid;
                            n_net   = i_tok.item.tnet;
                            n_asid  = i_tok.item.asid;
                            n_anet  = i_tok.item.anet;
                            n_tmo   = i_cfg.qto;
                            n_hold  = i_cfg.hold;
                            n_state = ST_QUERY;
                            o_res.status = STS_PENDING;
                            o_res.send   = 1'b1;
                        end else if (r_state == ST_QUERY) begin
                            if (r_tmo != 8'd0) begin
                                o_res.status = STS_PENDING;
                            end else if (r_hold == 8'd0) begin
                                n_tmo        = i_cfg.qto;
                                o_res.status = STS_PENDING;
                                o_res.send   = 1'b1;
                            end else begin
                                o_res.status = STS_DROPPED;
                            end
                        end else begin
                            o_res.status = STS_RESOLVED;
                        end
                    end
                end
                OP_RESPONSE: begin
                    // first matching valid entry takes the response
                    if (!i_tok.done && r_state != ST_INVALID) begin
                        if (i_tok.item.apres && id_hit) begin
                            n_tok.done = 1'b1;
                            if (r_state != ST_CACHED) begin
                                n_state     = ST_CACHED;
                                n_asid      = i_tok.item.asid;
                                n_anet      = i_tok.item.anet;
                                n_tmo       = 8'd0;
                                n_uid       = i_tok.item.tuid;
                                o_res_valid = 1'b1;
                                o_res.kind  = KIND_NOTIFY;
                            end
                        end else if (uid_hit) begin
                            n_tok.done = 1'b1;
                            if (r_state != ST_CACHED) begin
                                n_state     = ST_CACHED;
                                n_sid       = i_tok.item.tsid;
                                n_net       = i_tok.item.tnet;
                                n_asid      = i_tok.item.apres ? i_tok.item.asid
                                                               : i_cfg.inv_sid;
                                n_anet      = i_tok.item.apres ? i_tok.item.anet
                                                               : i_cfg.inv_net;
                                n_tmo       = 8'd0;
                                o_res_valid = 1'b1;
                                o_res.kind  = KIND_NOTIFY;
                            end
                        end
                    end
                end
                OP_UNREACH: begin
                    if (id_hit) begin
                        n_state = ST_INVALID;
                    end
                end
                OP_TICK: begin
                    // count down timeout, then retry hold
                    if (r_state == ST_QUERY) begin
                        if (r_tmo != 8'd0) begin
                            n_tmo = r_tmo - 8'd1;
                            if (r_tmo == 8'd1) begin
                                n_hold = i_cfg.hold;
                                if (i_tok.nres < NRES_W'(MAX_RESULTS)) begin
                                    n_tok.nres   = i_tok.nres + NRES_W'(1);
                                    o_res_valid  = 1'b1;
                                    o_res.kind   = KIND_NOTIFY;
                                    o_res.status = STS_DROPPED;
                                end
                            end
                        end else if (r_hold != 8'd0) begin
                            n_hold = r_hold - 8'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        // result shows the entry after the update
        o_res.idx  = 3'(IDX);
        o_res.sid  = n_sid;
        o_res.net  = n_net;
        o_res.uid  = n_uid;
        o_res.asid = n_asid;
        o_res.anet = n_anet;
    end

    // entry and token registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INVALID;
            r_uid       <= '0;
            r_sid       <= '0;
            r_net       <= '0;
            r_asid      <= '0;
            r_anet      <= '0;
            r_tmo       <= '0;
            r_hold      <= '0;
            r_tok.valid <= 1'b0;
        end else if (!i_stall) begin
            r_state <= n_state;
            r_uid   <= n_uid;
            r_sid   <= n_sid;
            r_net   <= n_net;
            r_asid  <= n_asid;
            r_anet  <= n_anet;
            r_tmo   <= n_tmo;
            r_hold  <= n_hold;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

/* hdl/mesh_address_resolution_cache.sv */
// mesh_address_resolution_cache: top level with token launch, result staging
// and apb registers; depends on marc_pkg and marc_cell
//
// usage: input requests arrive on the s_ stream group (tuser carries opcode and
// lookup kind), results leave on the m_ group with tlast on the final result
// of each request. the table is a row of TABLE_ENTRIES cells; a request token
// walks the row one cell per unstalled cycle and each cell updates its own entry.
// one request is in flight at a time. a response, unreachable or tick request
// walks the row once; a resolve walks the row twice (find, then act) when the
// find walk selects an entry, else it ends with a no-room result.
// a response whose attach ids hit a sentinel ends at once with no result.
// cell results pass through a one-deep holding stage before the output
// register. when a result must be pushed while the receiver stalls, the
// token and all cells hold until the output register frees up.
// reset (synchronous, active low) clears every entry to invalid and all ids
// to zero, and loads register defaults: timeout 3, hold 2, sentinels 65534.
// user must write registers over apb only while no request is in flight (unenforced).
module mesh_address_resolution_cache
    import marc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: target_short_id, target_network, target_unique_id, attach_present,
    //        attach_short_id, attach_network, zero fill
    input  logic [135:0] s_tdata,
    // tuser: opcode, query_kind
    input  logic [2:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status, send_query, entry_index, out_short_id, out_network,
    //        out_unique_id, out_attach_short_id, out_attach_network, zero fill
    output logic [135:0] m_tdata,
    // tuser: result_kind
    output logic         m_tuser,
    output logic         m_tlast,
    // apb register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_cfg    r_cfg;
    t_token  r_tok0, n_tok0;
    t_token  w_tok [0:TABLE_ENTRIES];
    logic    w_res_v [0:TABLE_ENTRIES-1];
    t_result w_res [0:TABLE_ENTRIES-1];
    logic    res_any;
    t_result res_data;
    t_item   in_item;

    logic    r_m_valid, n_m_valid;
    t_result r_m_data, n_m_data;
    logic    r_m_last, n_m_last;
    logic    r_p_valid, n_p_valid;
    t_result r_p, n_p;

    logic    busy, accept, drop_resp, stall, end_v, restart, end_res_v, finish;
    logic    push_needed, out_free;
    t_result no_room;

    // request unpack
    assign in_item.opcode = s_tuser[1:0];
    assign in_item.kind   = s_tuser[2];
    assign in_item.tsid   = s_tdata[15:0];
    assign in_item.tnet   = s_tdata[31:16];
    assign in_item.tuid   = s_tdata[95:32];
    assign in_item.apres  = s_tdata[96];
    assign in_item.asid   = s_tdata[112:97];
    assign in_item.anet   = s_tdata[128:113];

    // row of cells
    assign w_tok[0] = r_tok0;
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        marc_cell #(.IDX(g)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_stall     (stall),
            .i_cfg       (r_cfg),
            .i_tok       (w_tok[g]),
            .o_tok       (w_tok[g+1]),
            .o_res_valid (w_res_v[g]),
            .o_res       (w_res[g])
        );
    end

    // gather result and busy state along the row
    always_comb begin
        res_any  = 1'b0;
        res_data = '0;
        busy     = r_tok0.valid;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            res_any  = res_any | w_res_v[i];
            res_data = res_data | (w_res_v[i] ? w_res[i] : '0);
            busy     = busy | w_tok[i+1].valid;
        end
    end

    // walk end handling
    assign end_v     = w_tok[TABLE_ENTRIES].valid;
    assign restart   = end_v && (w_tok[TABLE_ENTRIES].item.opcode == OP_RESOLVE) &&
                       !w_tok[TABLE_ENTRIES].pass2 && w_tok[TABLE_ENTRIES].sel_set;
    assign end_res_v = end_v && (w_tok[TABLE_ENTRIES].item.opcode == OP_RESOLVE) &&
                       !w_tok[TABLE_ENTRIES].pass2 && !w_tok[TABLE_ENTRIES].sel_set;
    assign finish    = end_v && !restart;

    always_comb begin
        no_room        = '0;
        no_room.kind   = KIND_ANSWER;
        no_room.status = STS_NO_ROOM;
    end

    assign out_free    = !r_m_valid || m_tready;
    assign push_needed = (res_any && r_p_valid) || (finish && (r_p_valid || end_res_v));
    assign stall       = push_needed && !out_free;

    assign s_tready  = !busy;
    assign accept    = s_tvalid && !busy;
    assign drop_resp = (in_item.opcode == OP_RESPONSE) && in_item.apres &&
                       ((in_item.asid == r_cfg.inv_sid) || (in_item.anet == r_cfg.inv_net));

    // token launch and second-pass restart
    always_comb begin
        n_tok0 = r_tok0;
        if (accept) begin
            n_tok0.valid   = !drop_resp;
            n_tok0.pass2   = 1'b0;
            n_tok0.done    = 1'b0;
            n_tok0.sel_set = 1'b0;
            n_tok0.sel     = '0;
            n_tok0.nres    = '0;
            n_tok0.item    = in_item;
        end else if (!stall) begin
            if (restart) begin
                n_tok0       = w_tok[TABLE_ENTRIES];
                n_tok0.pass2 = 1'b1;
            end else begin
                n_tok0.valid = 1'b0;
            end
        end
    end

    // holding stage and output register
    always_comb begin
        n_p_valid = r_p_valid;
        n_p       = r_p;
        n_m_valid = r_m_valid && !m_tready;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;
        if (!stall) begin
            if (res_any) begin
                if (r_p_valid) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_p;
                    n_m_last  = 1'b0;
                end
                n_p_valid = 1'b1;
                n_p       = res_data;
            end else if (finish) begin
                if (end_res_v) begin
                    n_m_valid = 1'b1;
                    n_m_data  = no_room;
                    n_m_last  = 1'b1;
                end else if (r_p_valid) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_p;
                    n_m_last  = 1'b1;
                end
                n_p_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0.valid <= 1'b0;
            r_m_valid    <= 1'b0;
            r_p_valid    <= 1'b0;
        end else begin
            r_tok0    <= n_tok0;
            r_m_valid <= n_m_valid;
            r_p_valid <= n_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
        r_p      <= n_p;
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_m_data.kind;
    assign m_tlast  = r_m_last;
    assign m_tdata  = {2'b00, r_m_data.anet, r_m_data.asid, r_m_data.uid,
                       r_m_data.net, r_m_data.sid, r_m_data.idx, r_m_data.send,
                       r_m_data.status};

    // apb registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.qto     <= 8'd3;
            r_cfg.hold    <= 8'd2;
            r_cfg.inv_sid <= 16'd65534;
            r_cfg.inv_net <= 16'd65534;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_QTO:     r_cfg.qto     <= pwdata[7:0];
                REG_HOLD:    r_cfg.hold    <= pwdata[7:0];
                REG_INV_SID: r_cfg.inv_sid <= pwdata[15:0];
                REG_INV_NET: r_cfg.inv_net <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_QTO:     prdata = {24'd0, r_cfg.qto};
            REG_HOLD:    prdata = {24'd0, r_cfg.hold};
            REG_INV_SID: prdata = {16'd0, r_cfg.inv_sid};
            REG_INV_NET: prdata = {16'd0, r_cfg.inv_net};
            default:     prdata = '0;
        endcase
    end

endmodule
